### rtl/crsf_rx_pkg.sv
// ----------------------------------------------------------------------------
// CRSF receiver package
// Shared constants, result codes, register indexes and the structs that
// pass between the parser and the result sequencer.
// ----------------------------------------------------------------------------
package crsf_rx_pkg;

  // Frame buffer geometry
  localparam int MAX_FRAME_BYTES = 64;
  localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);

  // RC channel packing
  localparam int CHANNEL_COUNT   = 16;
  localparam int CHANNEL_BITS    = 11;
  localparam int CH_IDX_W        = 4;
  localparam int CH_BIT_W        = $clog2(CHANNEL_BITS + 1);
  localparam int RC_PAYLOAD_MIN  = (CHANNEL_COUNT * CHANNEL_BITS + 7) / 8;

  // Link statistics
  localparam int LINK_STAT_BYTES = 10;

  // Channel center value
  localparam int CENTER          = 1024;

  // Result kinds (also used as job codes toward the sequencer)
  localparam logic [1:0] KIND_CHAN = 2'd0;
  localparam logic [1:0] KIND_LINK = 2'd1;
  localparam logic [1:0] KIND_CRC  = 2'd2;
  localparam logic [1:0] KIND_LEN  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_CRC_POLY   = 3'd0;
  localparam logic [2:0] CFG_CTRL_ADDR  = 3'd1;
  localparam logic [2:0] CFG_RC_TYPE    = 3'd2;
  localparam logic [2:0] CFG_LINK_TYPE  = 3'd3;
  localparam logic [2:0] CFG_CENTER_DB  = 3'd4;
  localparam logic [2:0] CFG_THR_DB     = 3'd5;
  localparam logic [2:0] CFG_THR_CHAN   = 3'd6;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  crc_poly;
    logic [7:0]  ctrl_addr;
    logic [7:0]  rc_type;
    logic [7:0]  link_type;
    logic [10:0] center_band;
    logic [10:0] thr_band;
    logic [3:0]  thr_chan;
  } cfg_t;

  // Frame-end request to the result sequencer
  typedef struct packed {
    logic       start;
    logic [1:0] kind;
  } job_t;

endpackage

### rtl/crsf_rx_in_if.sv
// ----------------------------------------------------------------------------
// CRSF receiver input channel
// One received link byte per item, with the buffer start flag.
// ----------------------------------------------------------------------------
interface crsf_rx_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_start;

  modport source (output valid, output rx_byte, output buffer_start, input ready);
  modport sink   (input valid, input rx_byte, input buffer_start, output ready);
endinterface

### rtl/crsf_rx_out_if.sv
// ----------------------------------------------------------------------------
// CRSF receiver result channel
// One decoded channel, statistic byte or error per item.
// ----------------------------------------------------------------------------
interface crsf_rx_out_if ();
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [3:0]         item_index;
  logic [10:0]        raw_value;
  logic signed [11:0] scaled_value;
  logic               last_of_frame;

  modport source (output valid, output result_kind, output item_index,
                  output raw_value, output scaled_value, output last_of_frame,
                  input ready);
  modport sink   (input valid, input result_kind, input item_index,
                  input raw_value, input scaled_value, input last_of_frame,
                  output ready);
endinterface

### rtl/crsf_rx_cfg_if.sv
// ----------------------------------------------------------------------------
// CRSF receiver configuration write channel
// Register index and write data, written on a valid/ready handshake.
// ----------------------------------------------------------------------------
interface crsf_rx_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/crsf_rc_frame_receiver.sv
// Input: a byte is taken while the CRC unit and the sequencer are idle; a body byte
// other than the CRC byte then stalls the input while the bit-serial CRC unit folds
// it in. Frame end: an error result goes from the sequencer's emit state into the
// output register; RC frames take 11 shifts and 1 load per channel plus a two-state
// read per buffer byte, link frames a read and load per byte; input waits meanwhile.
// Reset (synchronous, rst_n low): registers to defaults, parser idle; buffer kept.
// ----------------------------------------------------------------------------
// CRSF RC frame receiver
// Parses address, length, type and payload of a link frame, checks the
// CRC-8 and hands finished frames to the result sequencer.
// ----------------------------------------------------------------------------
module crsf_rc_frame_receiver
  import crsf_rx_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  crsf_rx_in_if.sink    in_if,
  crsf_rx_cfg_if.sink   cfg_if,
  crsf_rx_out_if.source out_if
);

  // Parser phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  cfg_t              cfg_r;
  logic [1:0]        phase_r;
  logic [7:0]        addr_r;
  logic [7:0]        type_r;
  logic [ADDR_W-1:0] len_r;
  logic [ADDR_W-1:0] seen_r;

  logic              crc_busy;
  logic [7:0]        crc_val;
  logic              emit_busy;
  logic              accept;
  logic              crc_clear;
  logic              crc_start;
  logic              wr_en;
  logic              more_body;
  logic              bad_len;
  logic [ADDR_W-1:0] payload;
  job_t              job;

  // Configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_poly    <= 8'd213;
      cfg_r.ctrl_addr   <= 8'd200;
      cfg_r.rc_type     <= 8'd22;
      cfg_r.link_type   <= 8'd20;
      cfg_r.center_band <= 11'd30;
      cfg_r.thr_band    <= 11'd180;
      cfg_r.thr_chan    <= 4'd2;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_CRC_POLY:  cfg_r.crc_poly    <= cfg_if.data[7:0];
        CFG_CTRL_ADDR: cfg_r.ctrl_addr   <= cfg_if.data[7:0];
        CFG_RC_TYPE:   cfg_r.rc_type     <= cfg_if.data[7:0];
        CFG_LINK_TYPE: cfg_r.link_type   <= cfg_if.data[7:0];
        CFG_CENTER_DB: cfg_r.center_band <= cfg_if.data;
        CFG_THR_DB:    cfg_r.thr_band    <= cfg_if.data;
        CFG_THR_CHAN:  cfg_r.thr_chan    <= cfg_if.data[3:0];
        default: ;
      endcase
    end
  end

  // Input handshake: wait for the CRC shifter and the sequencer
  assign in_if.ready = !crc_busy && !emit_busy;
  assign accept      = in_if.valid && in_if.ready;

  // Parser decisions for the current item
  assign bad_len   = ({1'b0, in_if.rx_byte} < 9'd2) ||
                     ({1'b0, in_if.rx_byte} + 9'd2 > 9'(MAX_FRAME_BYTES));
  assign more_body = ({1'b0, seen_r} + (ADDR_W + 1)'(1)) < {1'b0, len_r};
  assign payload   = len_r - ADDR_W'(2);

  assign crc_clear = accept && in_if.buffer_start;
  assign wr_en     = accept && !in_if.buffer_start && (phase_r == PH_BODY);
  assign crc_start = wr_en && more_body;

  // Frame end request
  always_comb begin
    job.start = 1'b0;
    job.kind  = KIND_CHAN;
    if (accept && !in_if.buffer_start) begin
      if (phase_r == PH_LEN && bad_len) begin
        job.start = 1'b1;
        job.kind  = KIND_LEN;
      end else if (phase_r == PH_BODY && !more_body) begin
        if (crc_val != in_if.rx_byte) begin
          job.start = 1'b1;
          job.kind  = KIND_CRC;
        end else if (addr_r == cfg_r.ctrl_addr && type_r == cfg_r.rc_type) begin
          job.start = 1'b1;
          job.kind  = (payload < ADDR_W'(RC_PAYLOAD_MIN)) ? KIND_LEN : KIND_CHAN;
        end else if (addr_r == cfg_r.ctrl_addr && type_r == cfg_r.link_type) begin
          job.start = 1'b1;
          job.kind  = (payload < ADDR_W'(LINK_STAT_BYTES)) ? KIND_LEN : KIND_LINK;
        end
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= 8'd0;
      len_r   <= '0;
      seen_r  <= '0;
      type_r  <= 8'd0;
    end else if (accept) begin
      if (in_if.buffer_start) begin
        addr_r  <= in_if.rx_byte;
        len_r   <= '0;
        seen_r  <= '0;
        phase_r <= PH_LEN;
      end else begin
        case (phase_r)
          PH_LEN: begin
            if (bad_len) begin
              phase_r <= PH_DONE;
            end else begin
              len_r   <= ADDR_W'(in_if.rx_byte);
              phase_r <= PH_BODY;
            end
          end
          PH_BODY: begin
            if (seen_r == '0) begin
              type_r <= in_if.rx_byte;
            end
            seen_r <= seen_r + ADDR_W'(1);
            if (!more_body) begin
              phase_r <= PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  crsf_rx_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .poly  (cfg_r.crc_poly),
    .clear (crc_clear),
    .start (crc_start),
    .din   (in_if.rx_byte),
    .busy  (crc_busy),
    .crc   (crc_val)
  );

  crsf_rx_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .job     (job),
    .wr_en   (wr_en),
    .wr_addr (seen_r),
    .wr_data (in_if.rx_byte),
    .busy    (emit_busy),
    .out_if  (out_if)
  );

`ifndef SYNTHESIS
  a_job_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    job.start |-> !emit_busy) else $error("frame end while results pending");
  a_body_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> seen_r < len_r)
    else $error("body count past frame length");
`endif

endmodule

### rtl/crsf_rx_crc.sv
// ----------------------------------------------------------------------------
// CRSF receiver CRC-8 unit
// Bit-serial CRC-8, MSB first: each byte is XORed in, then folded in bit by bit.
// ----------------------------------------------------------------------------
module crsf_rx_crc
  import crsf_rx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] poly,
  input  logic       clear,
  input  logic       start,
  input  logic [7:0] din,
  output logic       busy,
  output logic [7:0] crc
);

  logic [7:0] crc_r;
  logic [3:0] cnt_r;

  assign busy = (cnt_r != 4'd0);
  assign crc  = crc_r;

  // Load the byte, then shift one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 8'd0;
      cnt_r <= 4'd0;
    end else if (clear) begin
      crc_r <= 8'd0;
      cnt_r <= 4'd0;
    end else if (start) begin
      crc_r <= crc_r ^ din;
      cnt_r <= 4'd8;
    end else if (busy) begin
      crc_r <= {crc_r[6:0], 1'b0} ^ (crc_r[7] ? poly : 8'd0);
      cnt_r <= cnt_r - 4'd1;
    end
  end

`ifndef SYNTHESIS
  a_no_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> cnt_r == 4'd0) else $error("crc start while shifting");
  a_no_clear_busy : assert property (@(posedge clk) disable iff (!rst_n)
    clear |-> cnt_r == 4'd0) else $error("crc clear while shifting");
`endif

endmodule

### rtl/crsf_rx_emit.sv
// ----------------------------------------------------------------------------
// CRSF receiver result sequencer
// Holds the frame buffer, unpacks channels one bit per cycle in its shift
// state, applies the dead zones and drives the registered result channel.
// ----------------------------------------------------------------------------
module crsf_rx_emit
  import crsf_rx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  job_t              job,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  output logic              busy,
  crsf_rx_out_if.source     out_if
);

  // Sequencer states
  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_RD1   = 3'd1;
  localparam logic [2:0] E_RD2   = 3'd2;
  localparam logic [2:0] E_SHIFT = 3'd3;
  localparam logic [2:0] E_EMIT  = 3'd4;

  logic [7:0]          store_mem [MAX_FRAME_BYTES];
  logic [7:0]          rdata_r;

  logic [2:0]          state_r;
  logic [1:0]          kind_r;
  logic [ADDR_W-1:0]   rd_addr_r;
  logic [7:0]          byte_r;
  logic [3:0]          byte_bits_r;
  logic [10:0]         chan_r;
  logic [CH_BIT_W-1:0] chan_bits_r;
  logic [CH_IDX_W-1:0] idx_r;

  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [3:0]          out_idx_r;
  logic [10:0]         out_raw_r;
  logic signed [11:0]  out_scaled_r;
  logic                out_last_r;

  logic                load;
  logic                last_item;
  logic signed [12:0]  zone_lo;
  logic signed [12:0]  zone_hi;
  logic signed [12:0]  chan_s;
  logic                in_zone;
  logic [10:0]         raw_nxt;
  logic signed [11:0]  scaled_nxt;

  assign busy = (state_r != E_IDLE);

  // Frame buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    rdata_r <= store_mem[rd_addr_r];
  end

  // Result values for the current item
  assign zone_lo = 13'sd1024 - $signed({2'b00, cfg.center_band});
  assign zone_hi = 13'sd1024 + $signed({2'b00, cfg.center_band});
  assign chan_s  = $signed({2'b00, chan_r});
  assign in_zone = (chan_s > zone_lo) && (chan_s < zone_hi);

  always_comb begin
    raw_nxt    = 11'd0;
    scaled_nxt = 12'sd0;
    last_item  = 1'b1;
    case (kind_r)
      KIND_CHAN: begin
        last_item = (idx_r == CH_IDX_W'(CHANNEL_COUNT - 1));
        if (idx_r == cfg.thr_chan) begin
          raw_nxt    = (chan_r < cfg.thr_band) ? 11'd0 : chan_r;
          scaled_nxt = $signed({1'b0, raw_nxt});
        end else begin
          raw_nxt    = in_zone ? 11'(CENTER) : chan_r;
          scaled_nxt = $signed(12'({1'b0, raw_nxt} - 12'(CENTER)));
        end
      end
      KIND_LINK: begin
        last_item = (idx_r == CH_IDX_W'(LINK_STAT_BYTES - 1));
        raw_nxt   = {3'b000, byte_r};
      end
      default: begin
        last_item = 1'b1;
      end
    endcase
  end

  assign load = (state_r == E_EMIT) && (!out_valid_r || out_if.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      kind_r      <= KIND_CHAN;
      rd_addr_r   <= '0;
      byte_bits_r <= 4'd0;
      chan_bits_r <= '0;
      idx_r       <= '0;
    end else begin
      case (state_r)
        E_IDLE: begin
          if (job.start) begin
            kind_r      <= job.kind;
            idx_r       <= '0;
            chan_bits_r <= '0;
            byte_bits_r <= 4'd0;
            rd_addr_r   <= ADDR_W'(1);
            if (job.kind == KIND_CHAN || job.kind == KIND_LINK) begin
              state_r <= E_RD1;
            end else begin
              state_r <= E_EMIT;
            end
          end
        end
        E_RD1: begin
          state_r <= E_RD2;
        end
        E_RD2: begin
          byte_r      <= rdata_r;
          byte_bits_r <= 4'd8;
          state_r     <= (kind_r == KIND_LINK) ? E_EMIT : E_SHIFT;
        end
        E_SHIFT: begin
          chan_r      <= {byte_r[0], chan_r[10:1]};
          byte_r      <= {1'b0, byte_r[7:1]};
          byte_bits_r <= byte_bits_r - 4'd1;
          if (chan_bits_r == CH_BIT_W'(CHANNEL_BITS - 1)) begin
            chan_bits_r <= '0;
            state_r     <= E_EMIT;
          end else begin
            chan_bits_r <= chan_bits_r + CH_BIT_W'(1);
            if (byte_bits_r == 4'd1) begin
              rd_addr_r <= rd_addr_r + ADDR_W'(1);
              state_r   <= E_RD1;
            end
          end
        end
        E_EMIT: begin
          if (load) begin
            if (last_item) begin
              state_r <= E_IDLE;
            end else begin
              idx_r <= idx_r + CH_IDX_W'(1);
              if (kind_r == KIND_CHAN && byte_bits_r != 4'd0) begin
                state_r <= E_SHIFT;
              end else begin
                rd_addr_r <= rd_addr_r + ADDR_W'(1);
                state_r   <= E_RD1;
              end
            end
          end
        end
        default: begin
          state_r <= E_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r   <= kind_r;
      out_idx_r    <= (kind_r == KIND_CHAN || kind_r == KIND_LINK) ? idx_r : 4'd0;
      out_raw_r    <= raw_nxt;
      out_scaled_r <= scaled_nxt;
      out_last_r   <= last_item;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.result_kind   = out_kind_r;
  assign out_if.item_index    = out_idx_r;
  assign out_if.raw_value     = out_raw_r;
  assign out_if.scaled_value  = out_scaled_r;
  assign out_if.last_of_frame = out_last_r;

`ifndef SYNTHESIS
  a_chan_last_idx : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_CHAN && out_last_r)
      |-> out_idx_r == CH_IDX_W'(CHANNEL_COUNT - 1))
    else $error("channel result flagged last before final channel");
  a_shift_has_bits : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == E_SHIFT) |-> (byte_bits_r != 4'd0 &&
      chan_bits_r < CH_BIT_W'(CHANNEL_BITS)))
    else $error("shift step without a bit to take");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRSF RC frame receiver testbench
// Feeds link byte streams through the input channel, decodes every accepted
// byte with a local frame parser, and checks each result item in order.
// Runs a directed set of frames, then random frame mixes under several
// register settings, with random idling on both sides and one long output
// hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import crsf_rx_pkg::*;

  localparam int IDLE_PCT      = 16;
  localparam int PHASE_BYTES   = 10;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 1500;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int CHAN_MAX      = (1 << CHANNEL_BITS) - 1;
  localparam int CHAN_FIELD_W  = CHANNEL_COUNT * CHANNEL_BITS;

  typedef enum logic [1:0] {AWAIT_START, GET_LEN, GET_BODY, FRAME_DONE} rx_state_e;

  typedef struct {
    bit [7:0] data;
    bit       start;
  } link_byte_t;

  typedef struct {
    logic [1:0]         kind;
    logic [3:0]         pos;
    logic [10:0]        raw;
    logic signed [11:0] scaled;
    logic               last;
  } decode_t;

  logic clk;
  logic rst_n;

  crsf_rx_in_if  in_if ();
  crsf_rx_out_if out_if ();
  crsf_rx_cfg_if cfg_if ();

  crsf_rc_frame_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .out_if (out_if)
  );

  // Byte stream waiting to be driven, and decoded results waiting to appear
  link_byte_t link_bytes_q[$];
  decode_t    decoded_q[$];
  link_byte_t next_byte;
  bit [7:0]   frame_body[$];
  bit [10:0]  chan_set[CHANNEL_COUNT];

  int  cycles;
  int  mismatches;
  int  results_seen;
  int  bytes_queued;
  bit  in_took;
  bit  calm;
  bit  hold_trig;
  bit  hold_seen;
  int  hold_left;

  // Local copy of the register set
  bit [7:0]  cfg_poly;
  bit [7:0]  cfg_addr;
  bit [7:0]  cfg_rc_type;
  bit [7:0]  cfg_link_type;
  bit [10:0] cfg_center_band;
  bit [10:0] cfg_thr_band;
  bit [3:0]  cfg_thr_chan;

  // Local frame parser state
  rx_state_e rx_state;
  bit [7:0]  rx_addr;
  int        rx_len;
  int        rx_count;
  bit [7:0]  rx_crc;
  bit [7:0]  frame_bytes[MAX_FRAME_BYTES];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CRC-8, MSB first
  function automatic bit [7:0] fold_crc(bit [7:0] crc, bit [7:0] b, bit [7:0] poly);
    bit [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    return c;
  endfunction

  function automatic void add_decode(logic [1:0] kind, int pos, int raw, int scaled,
                                     bit last);
    decode_t d;
    d.kind   = kind;
    d.pos    = 4'(pos);
    d.raw    = 11'(raw);
    d.scaled = 12'(scaled);
    d.last   = last;
    decoded_q.push_back(d);
  endfunction

  // Frame parser: one accepted byte in, zero or more results queued
  function automatic void decode_byte(bit [7:0] b, bit st);
    int       payload;
    int       v;
    int       sc;
    int       bitpos;
    bit [7:0] ftype;
    if (st) begin
      rx_addr  = b;
      rx_len   = 0;
      rx_count = 0;
      rx_crc   = 8'h00;
      rx_state = GET_LEN;
      return;
    end
    case (rx_state)
      GET_LEN: begin
        rx_len = int'(b);
        if (rx_len < 2 || rx_len + 2 > MAX_FRAME_BYTES) begin
          rx_state = FRAME_DONE;
          add_decode(KIND_LEN, 0, 0, 0, 1'b1);
        end else begin
          rx_state = GET_BODY;
        end
      end
      GET_BODY: begin
        frame_bytes[rx_count] = b;
        rx_count++;
        if (rx_count < rx_len) begin
          rx_crc = fold_crc(rx_crc, b, cfg_poly);
        end else begin
          rx_state = FRAME_DONE;
          payload  = rx_len - 2;
          ftype    = frame_bytes[0];
          if (rx_crc != frame_bytes[rx_len - 1]) begin
            add_decode(KIND_CRC, 0, 0, 0, 1'b1);
          end else if (rx_addr == cfg_addr) begin
            if (ftype == cfg_rc_type) begin
              if (payload < RC_PAYLOAD_MIN) begin
                add_decode(KIND_LEN, 0, 0, 0, 1'b1);
              end else begin
                for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                  // little-endian bit unpack after the type byte
                  v = 0;
                  for (int k = 0; k < CHANNEL_BITS; k++) begin
                    bitpos = ch * CHANNEL_BITS + k;
                    v |= int'(frame_bytes[1 + bitpos / 8][bitpos % 8]) << k;
                  end
                  if (ch == int'(cfg_thr_chan)) begin
                    if (v < int'(cfg_thr_band)) v = 0;
                    sc = v;
                  end else begin
                    if (v > CENTER - int'(cfg_center_band) &&
                        v < CENTER + int'(cfg_center_band)) v = CENTER;
                    sc = v - CENTER;
                  end
                  add_decode(KIND_CHAN, ch, v, sc, ch == CHANNEL_COUNT - 1);
                end
              end
            end else if (ftype == cfg_link_type) begin
              if (payload < LINK_STAT_BYTES) begin
                add_decode(KIND_LEN, 0, 0, 0, 1'b1);
              end else begin
                for (int i = 0; i < LINK_STAT_BYTES; i++)
                  add_decode(KIND_LINK, i, int'(frame_bytes[1 + i]), 0,
                             i == LINK_STAT_BYTES - 1);
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] result %0d: %s got %0d, want %0d", $time, results_seen, what,
               got, want);
  endtask

  // Sampling at the rising edge: registers, accepted bytes, results, timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** crsf_rc_frame_receiver: FAILED **");
      $finish;
    end
    in_took = in_if.valid && in_if.ready;
    if (!rst_n) begin
      cfg_poly        = 8'd213;
      cfg_addr        = 8'd200;
      cfg_rc_type     = 8'd22;
      cfg_link_type   = 8'd20;
      cfg_center_band = 11'd30;
      cfg_thr_band    = 11'd180;
      cfg_thr_chan    = 4'd2;
      rx_state        = AWAIT_START;
      rx_addr         = 8'h00;
      rx_len          = 0;
      rx_count        = 0;
      rx_crc          = 8'h00;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_CRC_POLY:  cfg_poly        = cfg_if.data[7:0];
          CFG_CTRL_ADDR: cfg_addr        = cfg_if.data[7:0];
          CFG_RC_TYPE:   cfg_rc_type     = cfg_if.data[7:0];
          CFG_LINK_TYPE: cfg_link_type   = cfg_if.data[7:0];
          CFG_CENTER_DB: cfg_center_band = cfg_if.data;
          CFG_THR_DB:    cfg_thr_band    = cfg_if.data;
          CFG_THR_CHAN:  cfg_thr_chan    = cfg_if.data[3:0];
          default: ;
        endcase
      end
      if (in_took) decode_byte(in_if.rx_byte, in_if.buffer_start);
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected item, kind", out_if.result_kind, -1);
        end else begin
          decode_t want;
          want = decoded_q.pop_front();
          if (out_if.result_kind !== want.kind)
            report_mismatch("result_kind", out_if.result_kind, want.kind);
          if (out_if.item_index !== want.pos)
            report_mismatch("item_index", out_if.item_index, want.pos);
          if (out_if.raw_value !== want.raw)
            report_mismatch("raw_value", out_if.raw_value, want.raw);
          if (out_if.scaled_value !== want.scaled)
            report_mismatch("scaled_value", out_if.scaled_value, want.scaled);
          if (out_if.last_of_frame !== want.last)
            report_mismatch("last_of_frame", out_if.last_of_frame, want.last);
        end
        results_seen++;
      end
    end
  end

  // Byte driver: next item at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (link_bytes_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_byte = link_bytes_q.pop_front();
        in_if.valid        <= 1'b1;
        in_if.rx_byte      <= next_byte.data;
        in_if.buffer_start <= next_byte.start;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, plus one long hold when triggered
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic push_byte(bit [7:0] b, bit st);
    link_byte_t lb;
    lb.data  = b;
    lb.start = st;
    link_bytes_q.push_back(lb);
    bytes_queued++;
  endtask

  // Address, length, type, frame_body and CRC; frame_body is consumed
  task automatic push_frame(bit [7:0] addr, bit [7:0] ftype, bit corrupt);
    bit [7:0] crc;
    crc = fold_crc(8'h00, ftype, cfg_poly);
    push_byte(addr, 1'b1);
    push_byte(8'(frame_body.size() + 2), 1'b0);
    push_byte(ftype, 1'b0);
    foreach (frame_body[i]) begin
      crc = fold_crc(crc, frame_body[i], cfg_poly);
      push_byte(frame_body[i], 1'b0);
    end
    if (corrupt) crc ^= 8'(1 << $urandom_range(7));
    push_byte(crc, 1'b0);
    frame_body.delete();
  endtask

  // Channel values biased toward the dead zone edges, the throttle threshold and the range ends
  task automatic random_channels();
    int v;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      case ($urandom_range(6))
        0: v = 0;
        1: v = CHAN_MAX;
        2: v = CENTER - int'(cfg_center_band) + int'($urandom_range(1));
        3: v = CENTER + int'(cfg_center_band) - int'($urandom_range(1));
        4: v = int'(cfg_thr_band) - int'($urandom_range(1));
        default: v = int'($urandom_range(CHAN_MAX));
      endcase
      if (v < 0) v = 0;
      if (v > CHAN_MAX) v = CHAN_MAX;
      chan_set[i] = 11'(v);
    end
  endtask

  task automatic load_rc_body(int extra);
    bit [CHAN_FIELD_W-1:0] chan_bits;
    for (int i = 0; i < CHANNEL_COUNT; i++)
      chan_bits[i * CHANNEL_BITS +: CHANNEL_BITS] = chan_set[i];
    for (int k = 0; k < RC_PAYLOAD_MIN; k++)
      frame_body.push_back(chan_bits[k * 8 +: 8]);
    repeat (extra) frame_body.push_back(8'($urandom));
  endtask

  task automatic load_random_body(int n);
    repeat (n) frame_body.push_back(8'($urandom));
  endtask

  // Well-formed frames half the time, with broken and foreign frames and noise mixed in
  task automatic run_random(int budget);
    int       mark;
    int       sel;
    int       n;
    int       len;
    bit [7:0] t;
    mark = bytes_queued;
    while (bytes_queued - mark < budget) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        random_channels();
        load_rc_body(($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0);
        push_frame(cfg_addr, cfg_rc_type, 1'b0);
      end else if (sel < 50) begin
        n = LINK_STAT_BYTES + (($urandom_range(3) == 0) ? $urandom_range(50) : 0);
        load_random_body(n);
        push_frame(cfg_addr, cfg_link_type, 1'b0);
      end else if (sel < 58) begin
        // CRC mismatch on an otherwise valid frame
        if ($urandom_range(1)) begin
          random_channels();
          load_rc_body(0);
          t = cfg_rc_type;
        end else begin
          load_random_body(LINK_STAT_BYTES);
          t = cfg_link_type;
        end
        push_frame(cfg_addr, t, 1'b1);
      end else if (sel < 64) begin
        // frame for another address
        t = $urandom_range(1) ? cfg_rc_type : 8'($urandom);
        load_random_body($urandom_range(RC_PAYLOAD_MIN + 4));
        push_frame(cfg_addr ^ 8'($urandom_range(1, 255)), t, 1'b0);
      end else if (sel < 70) begin
        // unknown frame type
        do t = 8'($urandom); while (t == cfg_rc_type || t == cfg_link_type);
        load_random_body($urandom_range(30));
        push_frame(cfg_addr, t, 1'b0);
      end else if (sel < 76) begin
        // payload too short for its type
        if ($urandom_range(1)) begin
          load_random_body($urandom_range(RC_PAYLOAD_MIN - 1));
          push_frame(cfg_addr, cfg_rc_type, 1'b0);
        end else begin
          load_random_body($urandom_range(LINK_STAT_BYTES - 1));
          push_frame(cfg_addr, cfg_link_type, 1'b0);
        end
      end else if (sel < 83) begin
        // impossible length, rest of buffer ignored
        len = $urandom_range(1) ? $urandom_range(1) : $urandom_range(MAX_FRAME_BYTES - 1, 255);
        push_byte(8'($urandom), 1'b1);
        push_byte(8'(len), 1'b0);
        repeat ($urandom_range(3)) push_byte(8'($urandom), 1'b0);
      end else if (sel < 91) begin
        // frame cut short by the next buffer start
        len = $urandom_range(2, MAX_FRAME_BYTES - 2);
        push_byte(cfg_addr, 1'b1);
        push_byte(8'(len), 1'b0);
        repeat ($urandom_range((len - 1 < 12) ? len - 1 : 12)) push_byte(8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic apply_config(bit [7:0] poly, bit [7:0] addr, bit [7:0] rc_t,
                              bit [7:0] link_t, bit [10:0] cband, bit [10:0] tband,
                              bit [3:0] tchan);
    write_reg(CFG_CRC_POLY, 11'(poly));
    write_reg(CFG_CTRL_ADDR, 11'(addr));
    write_reg(CFG_RC_TYPE, 11'(rc_t));
    write_reg(CFG_LINK_TYPE, 11'(link_t));
    write_reg(CFG_CENTER_DB, cband);
    write_reg(CFG_THR_DB, tband);
    write_reg(CFG_THR_CHAN, 11'(tchan));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every queued byte is taken and every result has come out
  task automatic drain();
    while (link_bytes_q.size() != 0 || in_if.valid || decoded_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    bit [7:0] rnd_rc;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.rx_byte      = 8'h00;
    in_if.buffer_start = 1'b0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_CRC_POLY;
    cfg_if.data        = 11'd0;
    calm               = 1'b0;
    hold_trig          = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset register values.
    // Bytes before any buffer start are ignored.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // impossible lengths, low and high, with a trailing byte that is ignored
    push_byte(cfg_addr, 1'b1);
    push_byte(8'd1, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(cfg_addr, 1'b1);
    push_byte(8'd0, 1'b0);
    push_byte(cfg_addr, 1'b1);
    push_byte(8'(MAX_FRAME_BYTES - 1), 1'b0);
    // partial frame dropped by a restart
    push_byte(cfg_addr, 1'b1);
    push_byte(8'd24, 1'b0);
    push_byte(cfg_rc_type, 1'b0);
    push_byte(8'hA5, 1'b0);
    // RC frame with both sides of each dead zone edge
    random_channels();
    chan_set[0] = 11'd0;
    chan_set[1] = 11'(CHAN_MAX);
    chan_set[3] = 11'(CENTER - int'(cfg_center_band));
    chan_set[4] = 11'(CENTER - int'(cfg_center_band) + 1);
    chan_set[5] = 11'(CENTER + int'(cfg_center_band) - 1);
    chan_set[6] = 11'(CENTER + int'(cfg_center_band));
    chan_set[7] = 11'(CENTER);
    chan_set[cfg_thr_chan] = cfg_thr_band - 11'd1;
    load_rc_body(0);
    push_frame(cfg_addr, cfg_rc_type, 1'b0);
    // link statistics, shortest and longest frames
    frame_body.push_back(8'h00);
    frame_body.push_back(8'hFF);
    load_random_body(LINK_STAT_BYTES - 2);
    push_frame(cfg_addr, cfg_link_type, 1'b0);
    load_random_body(MAX_FRAME_BYTES - 4);
    push_frame(cfg_addr, cfg_link_type, 1'b0);
    // bad CRC, foreign address, short payloads, unknown type
    load_random_body(LINK_STAT_BYTES);
    push_frame(cfg_addr, cfg_link_type, 1'b1);
    load_random_body(LINK_STAT_BYTES);
    push_frame(cfg_addr ^ 8'h01, cfg_link_type, 1'b0);
    load_random_body(RC_PAYLOAD_MIN - 1);
    push_frame(cfg_addr, cfg_rc_type, 1'b0);
    load_random_body(LINK_STAT_BYTES - 1);
    push_frame(cfg_addr, cfg_link_type, 1'b0);
    load_random_body(12);
    push_frame(cfg_addr, 8'h7E, 1'b0);
    drain();

    // Low extremes of the bands and the throttle index
    apply_config(8'h07, 8'hEE, 8'h16, 8'h14, 11'd0, 11'd0, 4'd0);
    run_random(PHASE_BYTES);
    drain();

    // High extremes; output held off long enough to back up the input
    apply_config(8'hFF, 8'h00, 8'hFF, 8'h00, 11'(CENTER), 11'(CHAN_MAX), 4'd15);
    hold_trig = ~hold_trig;
    random_channels();
    load_rc_body(0);
    push_frame(cfg_addr, cfg_rc_type, 1'b0);
    run_random(PHASE_BYTES);
    drain();

    // Zero polynomial, no idling on either side
    apply_config(8'h00, 8'hFF, 8'h00, 8'hFF, 11'($urandom_range(1, CENTER - 1)),
                 11'($urandom_range(CHAN_MAX)), 4'($urandom_range(15)));
    calm = 1'b1;
    run_random(PHASE_BYTES);
    drain();
    calm = 1'b0;

    // Random settings; RC and link types may collide, RC takes precedence
    rnd_rc = 8'($urandom);
    apply_config(8'($urandom), 8'($urandom), rnd_rc,
                 $urandom_range(1) ? rnd_rc : 8'($urandom),
                 11'($urandom_range(CENTER)), 11'($urandom_range(CHAN_MAX)),
                 4'($urandom_range(15)));
    run_random(PHASE_BYTES);
    drain();

    if (decoded_q.size() != 0)
      report_mismatch("results never delivered", 0, decoded_q.size());
    if (mismatches == 0)
      $display("** crsf_rc_frame_receiver: PASSED **");
    else
      $display("** crsf_rc_frame_receiver: FAILED **");
    $finish;
  end

endmodule
